// File: hw/rtl/fhp_pkg.sv
`timescale 1ns / 1ps
package fhp_pkg;
  typedef enum logic {
    OP_TWO_HALVES = 1'b0,
    OP_HALF_UV    = 1'b1
  } op_t;

  localparam logic [15:0] HALF_EXP_ONES = 16'h7c00;
  localparam logic [9:0]  HALF_QUIET    = 10'h200;
  localparam logic [15:0] UV_MAX        = 16'hffff;

  // decoded single, stage 1 -> stage 2
  typedef struct packed {
    logic        sign;
    logic        is_zero;   // underflows to signed zero
    logic        is_sub;    // subnormal half path
    logic        is_big;    // exp field gives infinity or NaN
    logic        is_nan;
    logic [3:0]  shift;     // 1 - e for subnormals, 1..11
    logic [4:0]  e;         // normal biased half exponent
    logic [23:0] mant;      // with hidden bit
  } dec_t;

  // rounded, stage 2 -> stage 3
  typedef struct packed {
    logic        sign;
    logic        is_zero;
    logic        is_sub;
    logic        is_big;
    logic        is_nan;
    logic [4:0]  e;
    logic [22:0] mant;
    logic [11:0] sh;        // subnormal value before round, bits 23..12
  } rnd_t;
endpackage

// File: hw/rtl/fhp_conv.sv
`timescale 1ns / 1ps
module fhp_conv (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        bits,
  output logic [15:0]        half
);
  import fhp_pkg::*;

  dec_t        d1;
  rnd_t        r2;
  dec_t        d_next;
  rnd_t        r_next;
  logic [15:0] h_next;
  logic [9:0]  e_s;
  logic [23:0] shifted;
  logic [23:0] nm;
  logic [5:0]  e_inc;
  logic [11:0] sub_r;

  // stage 1: classify
  always_comb begin
    e_s = {2'b00, bits[30:23]} - 10'd112;
    d_next.sign    = bits[31];
    d_next.is_zero = $signed(e_s) < -10;
    d_next.is_sub  = ($signed(e_s) <= 0) && !($signed(e_s) < -10);
    d_next.is_big  = !($signed(e_s) <= 0) && ($signed(e_s) >= 31);
    d_next.is_nan  = (bits[30:23] == 8'hff) && (bits[22:0] != 23'd0);
    d_next.shift   = 4'(10'd1 - e_s);
    d_next.e       = e_s[4:0];
    d_next.mant    = {1'b1, bits[22:0]};
  end

  // stage 2: shift for subnormals
  always_comb begin
    shifted = d1.mant >> d1.shift;
    r_next.sign    = d1.sign;
    r_next.is_zero = d1.is_zero;
    r_next.is_sub  = d1.is_sub;
    r_next.is_big  = d1.is_big;
    r_next.is_nan  = d1.is_nan;
    r_next.e       = d1.e;
    r_next.mant    = d1.mant[22:0];
    r_next.sh      = shifted[23:12];
  end

  // stage 3: round and assemble
  always_comb begin
    nm    = {1'b0, r2.mant} + (r2.mant[12] ? 24'h002000 : 24'h0);
    e_inc = {1'b0, r2.e} + 6'd1;
    sub_r = r2.sh + (r2.sh[0] ? 12'd2 : 12'd0);
    if (r2.is_zero) begin
      h_next = {r2.sign, 15'd0};
    end else if (r2.is_sub) begin
      h_next = {r2.sign, 4'd0, sub_r[11:1]};
    end else if (r2.is_big) begin
      if (r2.is_nan) begin
        h_next = {r2.sign, HALF_EXP_ONES[14:10],
                  (r2.mant[22:13] == 10'd0) ? HALF_QUIET : r2.mant[22:13]};
      end else begin
        h_next = {r2.sign, HALF_EXP_ONES[14:0]};
      end
    end else if (nm[23]) begin
      if (e_inc >= 6'd31) h_next = {r2.sign, HALF_EXP_ONES[14:0]};
      else h_next = {r2.sign, e_inc[4:0], 10'd0};
    end else begin
      h_next = {r2.sign, r2.e, nm[22:13]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1   <= d_next;
      r2   <= r_next;
      half <= h_next;
    end
  end
endmodule

// File: hw/rtl/float_to_half_packer_top.sv
`timescale 1ns / 1ps
// Float-to-half packer.
// s_axis carries one item per transfer; m_axis returns one packed word each.
// s_tdata: operation[0], first_value[32:1], second_value[64:33],
// uv_set[96:65], zero fill to 104 bits.
// m_tdata: packed_word. Mode 0 packs half(first) low and half(second) high;
// mode 1 packs half(first) low and uv_set clamped to 0..65535 high.
// The path is a three-stage pipeline: classify, subnormal shift, round and
// pack. One transfer per cycle is sustained while the output is not stalled.
// When m_tready is low while the last stage holds a word, all stages hold
// together and s_tready drops; nothing is lost or repeated.
// Reset (rst, synchronous) clears the valid bits; data registers are not reset.
module float_to_half_packer_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // operation, first_value, second_value, uv_set
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata    // packed_word
);
  import fhp_pkg::*;

  logic [2:0]  vld;
  logic [2:0]  op_d;
  logic [15:0] uv_d [3];
  logic [15:0] lo, hi;
  logic        en;
  logic [31:0] uv;
  logic [15:0] uv_c;

  assign en       = !vld[2] || m_tready;
  assign s_tready = en;
  assign uv       = s_tdata[96:65];
  assign uv_c     = uv[31] ? 16'd0 : (uv[30:16] != 15'd0) ? UV_MAX : uv[15:0];

  fhp_conv u_lo (.clk(clk), .en(en), .bits(s_tdata[32:1]), .half(lo));
  fhp_conv u_hi (.clk(clk), .en(en), .bits(s_tdata[64:33]), .half(hi));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 3'b000;
    end else if (en) begin
      vld <= {vld[1:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_d    <= {op_d[1:0], s_tdata[0]};
      uv_d[0] <= uv_c;
      uv_d[1] <= uv_d[0];
      uv_d[2] <= uv_d[1];
    end
  end

  assign m_tvalid = vld[2];
  assign m_tdata  = {(op_t'(op_d[2]) == OP_HALF_UV) ? uv_d[2] : hi, lo};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("ready low with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready ##1 s_tready ##1 s_tready |=> m_tvalid)
    else $error("item lost in pipeline");
endmodule
